// ----- sv/segment_fit_allocator_defines.svh -----
// assertion helpers used by segment_fit_allocator.sv
`ifndef SEGMENT_FIT_ALLOCATOR_DEFINES_SVH
`define SEGMENT_FIT_ALLOCATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SFA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define SFA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");

`endif

// ----- sv/sfa_pkg.sv -----
package sfa_pkg;

	// opcodes
	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_FREE    = 2'd1;
	localparam logic [1:0] OP_REALLOC = 2'd2;
	localparam logic [1:0] OP_REINIT  = 2'd3;

	// fit strategies
	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;
	localparam logic [1:0] FIT_UNDEF = 2'd3;

	// result status
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NOFIT   = 2'd1;
	localparam logic [1:0] STAT_BADADDR = 2'd2;

	// field widths of the words
	localparam int SIZE_W = 13;
	localparam int ADDR_W = 12;

	// flags from the segment evaluation unit
	typedef struct packed {
		logic fits;
		logic take;
		logic hit;
		logic merge;
		logic split_ok;
		logic same_size;
	} sfa_eval_t;

endpackage

// ----- sv/sfa_ram.sv -----
module sfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/sfa_alu.sv -----
module sfa_alu import sfa_pkg::*; #(
	parameter int AW        = 12,
	parameter int HDR_BYTES = 16
) (
	input  logic [AW-1:0]     ent_start,
	input  logic [AW-1:0]     ent_size,
	input  logic              ent_free,
	input  logic [SIZE_W-1:0] req,
	input  logic [ADDR_W-1:0] addr,
	input  logic [1:0]        strat,
	input  logic              sel_found,
	input  logic [AW-1:0]     sel_size,
	input  logic              pend_free,
	input  logic [AW-1:0]     pend_size,
	output sfa_eval_t         ev,
	output logic [AW-1:0]     merged_size,
	output logic [AW-1:0]     split_start,
	output logic [AW-1:0]     split_size,
	output logic [ADDR_W-1:0] pay_addr,
	output logic [SIZE_W-1:0] copy_len
);

	localparam int CW  = (AW > SIZE_W) ? AW : SIZE_W;
	localparam int CW1 = CW + 1;
	localparam int AW1 = AW + 1;
	localparam int HW  = (AW + 1 > ADDR_W) ? AW + 1 : ADDR_W;

	logic [CW-1:0]  size_w;
	logic [CW-1:0]  req_w;
	logic [CW-1:0]  rem;
	logic [CW:0]    split_sum;
	logic [AW:0]    merge_sum;
	logic [HW-1:0]  pay_full;
	logic           better;

	assign size_w = CW'(ent_size);
	assign req_w  = CW'(req);

	// fit test and strategy compare against the current pick
	assign ev.fits = ent_free && (size_w >= req_w);
	always_comb begin
		unique case (strat)
			FIT_BEST:  better = ent_size < sel_size;
			FIT_WORST: better = ent_size > sel_size;
			default:   better = 1'b0;
		endcase
	end
	assign ev.take = ev.fits && (!sel_found || better);

	// address match on an allocated segment
	assign pay_full = HW'(ent_start) + HW'(HDR_BYTES);
	assign ev.hit   = !ent_free && (pay_full == HW'(addr));
	assign pay_addr = pay_full[ADDR_W-1:0];

	// split of the remainder
	assign rem         = size_w - req_w;
	assign ev.split_ok = ev.fits && (rem >= CW'(HDR_BYTES));
	assign split_size  = AW'(rem - CW'(HDR_BYTES));
	assign split_sum   = CW1'(ent_start) + CW1'(HDR_BYTES) + CW1'(req);
	assign split_start = split_sum[AW-1:0];

	// coalescing with the pending segment
	assign ev.merge  = pend_free && (ent_free || ev.hit);
	assign merge_sum = AW1'(pend_size) + AW1'(HDR_BYTES) + AW1'(ent_size);
	assign merged_size = merge_sum[AW-1:0];

	// reallocate helpers
	assign ev.same_size = size_w == req_w;
	assign copy_len     = (size_w < req_w) ? size_w[SIZE_W-1:0] : req;

endmodule

// ----- sv/segment_fit_allocator.sv -----
// Segment-fit allocator: keeps a byte pool as an address-ordered segment table
// in one RAM and serves allocate, free, reallocate and reinitialise requests.
// Input words arrive on s_tvalid/s_tready with the opcode and fit strategy in
// s_tuser; each produces exactly one result word on m_tvalid/m_tready with the
// status in m_tuser. One request at a time: s_tready is high only when idle.
// Every table access goes through the single RAM read port; each entry
// visited takes an address state, then an evaluate state in the shared
// segment unit. An allocate that splits also moves the entries above the
// chosen segment up. Reinitialise and requests that fail early go straight
// to the output state. After reset the block writes the first table entry,
// then raises s_tready. The result sits in an output register; a stalled
// receiver holds it there, and the block can take the next request meanwhile
// but will not finish it until the previous word has been taken.
module segment_fit_allocator import sfa_pkg::*; #(
	parameter int POOL_BYTES = 4096,
	parameter int HDR_BYTES  = 16,
	parameter int MAX_SEGS   = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // request_size[12:0], block_address[24:13], zero fill
	input  logic [3:0]  s_tuser,   // opcode[1:0], fit_strategy[3:2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // result_address[11:0], copy_length[24:12], zero fill
	output logic [1:0]  m_tuser    // status[1:0]
);

	`include "segment_fit_allocator_defines.svh"

	localparam int AW   = $clog2(POOL_BYTES);
	localparam int IW   = $clog2(MAX_SEGS);
	localparam int CNTW = $clog2(MAX_SEGS + 1);
	localparam int EW   = 2 * AW + 1;

	typedef enum logic [14:0] {
		ST_INIT = 15'h0001,
		ST_IDLE = 15'h0002,
		ST_FRD  = 15'h0004,
		ST_FEV  = 15'h0008,
		ST_ARD  = 15'h0010,
		ST_AEV  = 15'h0020,
		ST_ASPL = 15'h0040,
		ST_SRD  = 15'h0080,
		ST_SWR  = 15'h0100,
		ST_AWR1 = 15'h0200,
		ST_AWR0 = 15'h0400,
		ST_CRD  = 15'h0800,
		ST_CEV  = 15'h1000,
		ST_CWR  = 15'h2000,
		ST_OUT  = 15'h4000
	} state_t;

	localparam logic [EW-1:0] ENTRY0 = {AW'(0), AW'(POOL_BYTES - HDR_BYTES), 1'b1};

	// control state
	state_t            state_q, state_d;
	logic [CNTW-1:0]   cnt_q, cnt_d;
	logic              m_tvalid_q, m_tvalid_d;

	// request and working registers
	logic [1:0]        op_q, op_d;
	logic [1:0]        strat_q, strat_d;
	logic [SIZE_W-1:0] req_q, req_d;
	logic [ADDR_W-1:0] addr_q, addr_d;
	logic [CNTW-1:0]   idx_q, idx_d;
	logic [CNTW-1:0]   wr_q, wr_d;
	logic [IW-1:0]     sel_q, sel_d;
	logic [AW-1:0]     sel_start_q, sel_start_d;
	logic [AW-1:0]     sel_size_q, sel_size_d;
	logic              sel_found_q, sel_found_d;
	logic [SIZE_W-1:0] copy_pend_q, copy_pend_d;
	logic [AW-1:0]     pend_start_q, pend_start_d;
	logic [AW-1:0]     pend_size_q, pend_size_d;
	logic              pend_free_q, pend_free_d;
	logic [1:0]        status_q, status_d;
	logic [ADDR_W-1:0] res_q, res_d;
	logic [SIZE_W-1:0] copy_q, copy_d;
	logic [31:0]       m_tdata_q, m_tdata_d;
	logic [1:0]        m_tuser_q, m_tuser_d;

	// table RAM
	logic              we;
	logic [IW-1:0]     waddr;
	logic [EW-1:0]     wdata;
	logic [IW-1:0]     raddr;
	logic [EW-1:0]     rdata;

	logic [AW-1:0]     rd_start, rd_size;
	logic              rd_free;

	// evaluation unit
	logic              use_sel;
	logic [AW-1:0]     ent_start, ent_size;
	logic              ent_free;
	sfa_eval_t         ev;
	logic [AW-1:0]     merged_size, split_start, split_size;
	logic [ADDR_W-1:0] pay_addr;
	logic [SIZE_W-1:0] copy_len;

	logic              last;
	logic [CNTW-1:0]   sel_inc, wr_inc;
	logic [1:0]        op_in, strat_in;
	logic [SIZE_W-1:0] req_in;
	logic [ADDR_W-1:0] addr_in;

	sfa_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_SEGS)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_start = rdata[EW-1:AW+1];
	assign rd_size  = rdata[AW:1];
	assign rd_free  = rdata[0];

	// the evaluation unit sees the chosen segment while splitting, else the RAM word
	assign use_sel   = (state_q == ST_ASPL) || (state_q == ST_AWR1);
	assign ent_start = use_sel ? sel_start_q : rd_start;
	assign ent_size  = use_sel ? sel_size_q  : rd_size;
	assign ent_free  = use_sel ? 1'b1        : rd_free;

	sfa_alu #(
		.AW(AW),
		.HDR_BYTES(HDR_BYTES)
	) u_alu (
		.ent_start  (ent_start),
		.ent_size   (ent_size),
		.ent_free   (ent_free),
		.req        (req_q),
		.addr       (addr_q),
		.strat      (strat_q),
		.sel_found  (sel_found_q),
		.sel_size   (sel_size_q),
		.pend_free  (pend_free_q),
		.pend_size  (pend_size_q),
		.ev         (ev),
		.merged_size(merged_size),
		.split_start(split_start),
		.split_size (split_size),
		.pay_addr   (pay_addr),
		.copy_len   (copy_len)
	);

	assign last    = (idx_q + 1'b1) == cnt_q;
	assign sel_inc = CNTW'(sel_q) + 1'b1;
	assign wr_inc  = wr_q + 1'b1;
	assign op_in    = s_tuser[1:0];
	assign strat_in = s_tuser[3:2];
	assign req_in   = s_tdata[12:0];
	assign addr_in  = s_tdata[24:13];

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// sequencer
	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		m_tvalid_d   = m_tvalid_q && !m_tready;
		op_d         = op_q;
		strat_d      = strat_q;
		req_d        = req_q;
		addr_d       = addr_q;
		idx_d        = idx_q;
		wr_d         = wr_q;
		sel_d        = sel_q;
		sel_start_d  = sel_start_q;
		sel_size_d   = sel_size_q;
		sel_found_d  = sel_found_q;
		copy_pend_d  = copy_pend_q;
		pend_start_d = pend_start_q;
		pend_size_d  = pend_size_q;
		pend_free_d  = pend_free_q;
		status_d     = status_q;
		res_d        = res_q;
		copy_d       = copy_q;
		m_tdata_d    = m_tdata_q;
		m_tuser_d    = m_tuser_q;
		we           = 1'b0;
		waddr        = '0;
		wdata        = '0;
		raddr        = idx_q[IW-1:0];

		unique case (state_q)
			ST_INIT: begin
				we      = 1'b1;
				wdata   = ENTRY0;
				cnt_d   = CNTW'(1);
				state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					op_d        = op_in;
					strat_d     = strat_in;
					req_d       = req_in;
					addr_d      = addr_in;
					status_d    = STAT_OK;
					res_d       = '0;
					copy_d      = '0;
					idx_d       = '0;
					wr_d        = '0;
					sel_found_d = 1'b0;
					unique case (op_in)
						OP_ALLOC: begin
							if (strat_in == FIT_UNDEF) begin
								status_d = STAT_NOFIT;
								state_d  = ST_OUT;
							end else begin
								state_d = ST_ARD;
							end
						end
						OP_FREE: begin
							state_d = (addr_in == '0) ? ST_OUT : ST_FRD;
						end
						OP_REALLOC: begin
							strat_d = FIT_FIRST;
							state_d = (addr_in == '0) ? ST_ARD : ST_FRD;
						end
						OP_REINIT: begin
							we      = 1'b1;
							wdata   = ENTRY0;
							cnt_d   = CNTW'(1);
							state_d = ST_OUT;
						end
						default: state_d = ST_OUT;
					endcase
				end
			end
			// look up the allocated segment named by the address
			ST_FRD: state_d = ST_FEV;
			ST_FEV: begin
				if (ev.hit) begin
					copy_pend_d = copy_len;
					idx_d       = '0;
					wr_d        = '0;
					if (op_q == OP_FREE || req_q == '0) begin
						state_d = ST_CRD;
					end else if (ev.same_size) begin
						res_d   = addr_q;
						state_d = ST_OUT;
					end else begin
						state_d = ST_ARD;
					end
				end else if (last) begin
					status_d = STAT_BADADDR;
					state_d  = ST_OUT;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = ST_FRD;
				end
			end
			// fit scan over all segments
			ST_ARD: state_d = ST_AEV;
			ST_AEV: begin
				if (ev.take) begin
					sel_d       = idx_q[IW-1:0];
					sel_start_d = rd_start;
					sel_size_d  = rd_size;
					sel_found_d = 1'b1;
				end
				if (last) begin
					if (sel_found_q || ev.take) begin
						state_d = ST_ASPL;
					end else begin
						status_d = STAT_NOFIT;
						state_d  = ST_OUT;
					end
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = ST_ARD;
				end
			end
			// split decision on the chosen segment
			ST_ASPL: begin
				res_d = pay_addr;
				if (ev.split_ok && cnt_q != CNTW'(MAX_SEGS)) begin
					if (sel_inc != cnt_q) begin
						wr_d    = cnt_q - 1'b1;
						state_d = ST_SRD;
					end else begin
						state_d = ST_AWR1;
					end
				end else begin
					state_d = ST_AWR0;
				end
			end
			// move the entries above the split up by one, top first
			ST_SRD: begin
				raddr   = wr_q[IW-1:0];
				state_d = ST_SWR;
			end
			ST_SWR: begin
				we    = 1'b1;
				waddr = wr_inc[IW-1:0];
				wdata = rdata;
				if (wr_q == sel_inc) begin
					state_d = ST_AWR1;
				end else begin
					wr_d    = wr_q - 1'b1;
					state_d = ST_SRD;
				end
			end
			ST_AWR1: begin
				we         = 1'b1;
				waddr      = sel_inc[IW-1:0];
				wdata      = {split_start, split_size, 1'b1};
				cnt_d      = cnt_q + 1'b1;
				sel_size_d = AW'(req_q);
				state_d    = ST_AWR0;
			end
			ST_AWR0: begin
				we    = 1'b1;
				waddr = sel_q;
				wdata = {sel_start_q, sel_size_q, 1'b0};
				if (op_q == OP_REALLOC && addr_q != '0) begin
					copy_d  = copy_pend_q;
					idx_d   = '0;
					wr_d    = '0;
					state_d = ST_CRD;
				end else begin
					state_d = ST_OUT;
				end
			end
			// release pass: mark the block free and coalesce free runs
			ST_CRD: state_d = ST_CEV;
			ST_CEV: begin
				if (idx_q == '0) begin
					pend_start_d = rd_start;
					pend_size_d  = rd_size;
					pend_free_d  = rd_free || ev.hit;
				end else if (ev.merge) begin
					pend_size_d = merged_size;
				end else begin
					we           = 1'b1;
					waddr        = wr_q[IW-1:0];
					wdata        = {pend_start_q, pend_size_q, pend_free_q};
					wr_d         = wr_inc;
					pend_start_d = rd_start;
					pend_size_d  = rd_size;
					pend_free_d  = rd_free || ev.hit;
				end
				if (last) begin
					state_d = ST_CWR;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = ST_CRD;
				end
			end
			ST_CWR: begin
				we      = 1'b1;
				waddr   = wr_q[IW-1:0];
				wdata   = {pend_start_q, pend_size_q, pend_free_q};
				cnt_d   = wr_inc;
				state_d = ST_OUT;
			end
			// hand the result word to the output register
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					m_tvalid_d = 1'b1;
					m_tdata_d  = {7'b0, copy_q, res_q};
					m_tuser_d  = status_q;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			cnt_q      <= CNTW'(1);
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			m_tvalid_q <= m_tvalid_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		op_q         <= op_d;
		strat_q      <= strat_d;
		req_q        <= req_d;
		addr_q       <= addr_d;
		idx_q        <= idx_d;
		wr_q         <= wr_d;
		sel_q        <= sel_d;
		sel_start_q  <= sel_start_d;
		sel_size_q   <= sel_size_d;
		sel_found_q  <= sel_found_d;
		copy_pend_q  <= copy_pend_d;
		pend_start_q <= pend_start_d;
		pend_size_q  <= pend_size_d;
		pend_free_q  <= pend_free_d;
		status_q     <= status_d;
		res_q        <= res_d;
		copy_q       <= copy_d;
		m_tdata_q    <= m_tdata_d;
		m_tuser_q    <= m_tuser_d;
	end

	// checks
	`SFA_ASSERT_NOW(a_cnt_range, 1'b1, (cnt_q != '0) && (cnt_q <= CNTW'(MAX_SEGS)))
	`SFA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	`SFA_ASSERT_NEXT(a_split_grows, state_q == ST_AWR1, cnt_q == $past(cnt_q) + 1'b1)
	`SFA_ASSERT_NOW(a_status_code, m_tvalid, m_tuser != 2'd3)

endmodule

// ----- dv/segment_fit_checker.sv -----
`timescale 1ns / 100ps

// watches both channels of the allocator, predicts each result word and compares
module segment_fit_checker import sfa_pkg::*; #(
	parameter int POOL_BYTES = 4096,
	parameter int HDR_BYTES  = 16,
	parameter int MAX_SEGS   = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic [3:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic [1:0]  m_tuser,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] addr;
		logic [12:0] copy;
	} alloc_result_t;

	// shadow segment table
	int unsigned seg_start [MAX_SEGS];
	int unsigned seg_size [MAX_SEGS];
	bit          seg_free [MAX_SEGS];
	int unsigned seg_count;

	alloc_result_t expected_words[$];

	function automatic void table_reset();
		seg_start[0] = 0;
		seg_size[0] = POOL_BYTES - HDR_BYTES;
		seg_free[0] = 1'b1;
		seg_count = 1;
	endfunction

	function automatic void table_remove(int unsigned i);
		for (int unsigned j = i; j + 1 < seg_count; j++) begin
			seg_start[j] = seg_start[j+1];
			seg_size[j] = seg_size[j+1];
			seg_free[j] = seg_free[j+1];
		end
		seg_count--;
	endfunction

	function automatic void coalesce();
		int unsigned i;
		i = 0;
		while (i + 1 < seg_count) begin
			if (seg_free[i] && seg_free[i+1]) begin
				seg_size[i] += HDR_BYTES + seg_size[i+1];
				table_remove(i + 1);
			end else begin
				i++;
			end
		end
	endfunction

	function automatic int lookup(int unsigned a);
		for (int unsigned i = 0; i < seg_count; i++)
			if (!seg_free[i] && seg_start[i] + HDR_BYTES == a)
				return int'(i);
		return -1;
	endfunction

	function automatic logic [1:0] grant(int unsigned req, logic [1:0] strat,
			output int unsigned a);
		int unsigned sel, rem;
		bit found;
		sel = 0;
		found = 0;
		a = 0;
		if (strat == FIT_UNDEF)
			return STAT_NOFIT;
		for (int unsigned i = 0; i < seg_count; i++) begin
			if (!seg_free[i] || seg_size[i] < req)
				continue;
			if (!found) begin
				sel = i;
				found = 1;
				if (strat == FIT_FIRST)
					break;
			end else if (strat == FIT_BEST && seg_size[i] < seg_size[sel]) begin
				sel = i;
			end else if (strat == FIT_WORST && seg_size[i] > seg_size[sel]) begin
				sel = i;
			end
		end
		if (!found)
			return STAT_NOFIT;
		rem = seg_size[sel] - req;
		// split off the tail when a header fits and the table has room
		if (rem >= HDR_BYTES && seg_count < MAX_SEGS) begin
			for (int unsigned j = seg_count; j > sel + 1; j--) begin
				seg_start[j] = seg_start[j-1];
				seg_size[j] = seg_size[j-1];
				seg_free[j] = seg_free[j-1];
			end
			seg_count++;
			seg_start[sel+1] = seg_start[sel] + HDR_BYTES + req;
			seg_size[sel+1] = rem - HDR_BYTES;
			seg_free[sel+1] = 1'b1;
			seg_size[sel] = req;
		end
		seg_free[sel] = 1'b0;
		a = seg_start[sel] + HDR_BYTES;
		return STAT_OK;
	endfunction

	function automatic logic [1:0] release_block(int unsigned a);
		int k;
		if (a == 0)
			return STAT_OK;
		k = lookup(a);
		if (k < 0)
			return STAT_BADADDR;
		seg_free[k] = 1'b1;
		coalesce();
		return STAT_OK;
	endfunction

	function automatic alloc_result_t predict_word(logic [1:0] op, logic [1:0] strat,
			int unsigned req, int unsigned a);
		alloc_result_t r;
		int unsigned got, old;
		int k;
		logic [1:0] dummy;
		r = '0;
		got = 0;
		case (op)
			OP_ALLOC: r.status = grant(req, strat, got);
			OP_FREE: r.status = release_block(a);
			OP_REALLOC: begin
				if (a == 0) begin
					r.status = grant(req, FIT_FIRST, got);
				end else begin
					k = lookup(a);
					if (k < 0) begin
						r.status = STAT_BADADDR;
					end else if (req == 0) begin
						r.status = release_block(a);
					end else if (seg_size[k] == req) begin
						got = a;
					end else begin
						old = seg_size[k];
						r.status = grant(req, FIT_FIRST, got);
						if (r.status == STAT_OK) begin
							r.copy = 13'((old < req) ? old : req);
							dummy = release_block(a);
						end
					end
				end
			end
			default: table_reset();
		endcase
		r.addr = 12'(got);
		return r;
	endfunction

	assign pending = expected_words.size();

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t e;
		int errs;
		errs = 0;
		if (!arst_n) begin
			table_reset();
			expected_words.delete();
			fail_count <= 0;
		end else begin
			// accepted request word
			if (s_tvalid && s_tready)
				expected_words.push_back(predict_word(s_tuser[1:0], s_tuser[3:2],
					32'(s_tdata[12:0]), 32'(s_tdata[24:13])));
			// accepted result word
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					$error("result word with nothing expected");
					errs++;
				end else begin
					e = expected_words.pop_front();
					if (m_tuser != e.status) begin
						$error("status: expected %0d actual %0d", e.status, m_tuser);
						errs++;
					end
					if (m_tdata[11:0] != e.addr) begin
						$error("result_address: expected %0d actual %0d", e.addr,
							m_tdata[11:0]);
						errs++;
					end
					if (m_tdata[24:12] != e.copy) begin
						$error("copy_length: expected %0d actual %0d", e.copy,
							m_tdata[24:12]);
						errs++;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
	end

endmodule

// ----- dv/tb_segment_fit_allocator.sv -----
`timescale 1ns / 100ps

module tb_segment_fit_allocator;
	import sfa_pkg::*;

	localparam int WATCHDOG = 200000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [3:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	int          fail_count;
	int          pending;
	bit          hold_off;
	bit          sending_done;
	int          idle_cycles;

	// addresses granted so far, used to make frees and reallocates hit
	logic [11:0] live_blocks[$];

	segment_fit_allocator uut (.*);

	segment_fit_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// track granted blocks from the result side
	always @(posedge clk) begin
		if (m_tvalid && m_tready && m_tuser == STAT_OK && m_tdata[11:0] != 0
				&& live_blocks.size() < 64)
			live_blocks.push_back(m_tdata[11:0]);
	end

	// receiver stall pattern, with one long hold-off
	initial begin
		int k;
		m_tready = 1'b0;
		k = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			k++;
			if (hold_off)
				m_tready <= 1'b0;
			else if ((k / 40) % 3 == 0)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	initial begin
		hold_off = 1'b0;
		wait (sending_done == 0 && arst_n);
		repeat (3000) @(posedge clk);
		hold_off = 1'b1;
		repeat (2000) @(posedge clk);
		hold_off = 1'b0;
	end

	// watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_word(logic [1:0] op, logic [1:0] strat, logic [12:0] req,
			logic [11:0] a);
		s_tvalid <= 1'b1;
		s_tuser <= {strat, op};
		s_tdata <= {7'd0, a, req};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	function automatic logic [11:0] pick_addr();
		int i;
		logic [11:0] a;
		if (live_blocks.size() == 0 || $urandom_range(0, 9) == 0)
			return 12'($urandom_range(0, 4095));
		i = $urandom_range(0, live_blocks.size() - 1);
		a = live_blocks[i];
		live_blocks.delete(i);
		return a;
	endfunction

	task automatic random_word();
		int r;
		logic [12:0] sz;
		r = $urandom_range(0, 99);
		sz = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(0, 8191)) :
			13'($urandom_range(0, 96));
		if (r < 45)
			send_word(OP_ALLOC, 2'($urandom_range(0, 3)), sz,
				12'($urandom_range(0, 4095)));
		else if (r < 75)
			send_word(OP_FREE, 2'($urandom_range(0, 3)), sz, pick_addr());
		else if (r < 97)
			send_word(OP_REALLOC, 2'($urandom_range(0, 3)), sz, pick_addr());
		else begin
			live_blocks.delete();
			send_word(OP_REINIT, 2'($urandom_range(0, 3)), sz,
				12'($urandom_range(0, 4095)));
		end
	endtask

	initial begin
		int gap;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		sending_done = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, each fit, special cases
		send_word(OP_ALLOC, FIT_FIRST, 13'd4096, 12'd0);
		send_word(OP_ALLOC, FIT_FIRST, 13'd4080, 12'd0);
		send_word(OP_FREE, FIT_FIRST, 13'd0, 12'd16);
		send_word(OP_FREE, FIT_FIRST, 13'd0, 12'd0);
		send_word(OP_FREE, FIT_FIRST, 13'd0, 12'd4095);
		send_word(OP_ALLOC, FIT_UNDEF, 13'd10, 12'd0);
		send_word(OP_ALLOC, FIT_FIRST, 13'd100, 12'd0);
		send_word(OP_ALLOC, FIT_FIRST, 13'd40, 12'd0);
		send_word(OP_ALLOC, FIT_FIRST, 13'd200, 12'd0);
		send_word(OP_ALLOC, FIT_FIRST, 13'd8, 12'd0);
		send_word(OP_FREE, FIT_FIRST, 13'd0, 12'd16);
		send_word(OP_FREE, FIT_FIRST, 13'd0, 12'd264);
		send_word(OP_ALLOC, FIT_BEST, 13'd30, 12'd0);
		send_word(OP_ALLOC, FIT_WORST, 13'd0, 12'd0);
		send_word(OP_REALLOC, FIT_FIRST, 13'd20, 12'd0);
		send_word(OP_REALLOC, FIT_FIRST, 13'd40, 12'd132);
		send_word(OP_REALLOC, FIT_FIRST, 13'd300, 12'd132);
		send_word(OP_REALLOC, FIT_FIRST, 13'd8191, 12'd188);
		send_word(OP_REALLOC, FIT_FIRST, 13'd0, 12'd188);
		send_word(OP_REALLOC, FIT_FIRST, 13'd5, 12'd4095);
		send_word(OP_REINIT, FIT_WORST, 13'h1FFF, 12'hFFF);
		// fill the table so the no-split path is hit
		for (int i = 0; i < 300; i++)
			send_word(OP_ALLOC, FIT_FIRST, 13'd0, 12'd0);
		send_word(OP_REINIT, FIT_FIRST, 13'd0, 12'd0);
		s_tvalid <= 1'b0;
		live_blocks.delete();
		@(posedge clk);

		// random bursts and gaps
		for (int n = 0; n < 580; n++) begin
			random_word();
			if ($urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 12);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b0;
		sending_done = 1;

		wait (pending == 0);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- segment_fit_allocator.f -----
+incdir+sv
sv/sfa_pkg.sv
sv/sfa_ram.sv
sv/sfa_alu.sv
sv/segment_fit_allocator.sv
dv/segment_fit_checker.sv
dv/tb_segment_fit_allocator.sv
